[rtl/core/stcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcl_pkg
// Shared types and constants for the skin tone pixel classifier: channel
// payloads, register indexes and the pipeline item of the saturation divider.
// ----------------------------------------------------------------------------
package stcl_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_HUE_CENTER        = 3'd0;
  localparam logic [2:0] REG_HUE_MARGIN        = 3'd1;
  localparam logic [2:0] REG_LIGHTNESS_CENTER  = 3'd2;
  localparam logic [2:0] REG_LIGHTNESS_MARGIN  = 3'd3;
  localparam logic [2:0] REG_SATURATION_CENTER = 3'd4;
  localparam logic [2:0] REG_SATURATION_MARGIN = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // One quotient bit per divider stage; saturation is at most 100
  localparam int DIV_STEPS = 7;
  localparam int DIV_W     = 15;

  localparam logic [23:0] MASK_HIT  = 24'hFFFFFF;
  localparam logic [23:0] MASK_MISS = 24'h000000;
  localparam logic [6:0]  SAT_MAX   = 7'd100;

  typedef struct packed {
    logic [23:0] pixel_word;
    logic        last_pixel;
  } stcl_in_t;

  typedef struct packed {
    logic [23:0] mask_word;
    logic        last_out;
  } stcl_out_t;

  // Item carried through the saturation divider
  typedef struct packed {
    logic signed [9:0]      hue;
    logic [7:0]             light;
    logic                   last;
    logic                   zero;
    logic [DIV_W-1:0]       rem;
    logic [DIV_W-1:0]       dsor;
    logic [DIV_STEPS-1:0]   quot;
  } stcl_pipe_t;

endpackage

[rtl/core/stcl_div_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcl_div_step
// One restoring division step of the saturation divider: compares the
// remainder against the aligned divisor, shifts in one quotient bit and
// moves the divisor one place right. Holds its item while not advancing.
// ----------------------------------------------------------------------------
module stcl_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  stcl_pkg::stcl_pipe_t in_item,
  output logic                out_valid,
  output stcl_pkg::stcl_pipe_t out_item
);

  stcl_pkg::stcl_pipe_t item_next;
  logic                 fits;

  // Subtract the divisor where it fits, record the quotient bit
  always_comb begin
    fits      = (in_item.rem >= in_item.dsor);
    item_next = in_item;
    if (fits) begin
      item_next.rem = in_item.rem - in_item.dsor;
    end
    item_next.quot = {in_item.quot[stcl_pkg::DIV_STEPS-2:0], fits};
    item_next.dsor = {1'b0, in_item.dsor[stcl_pkg::DIV_W-1:1]};
  end

  // Valid bit travels with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= item_next;
    end
  end

endmodule

[rtl/core/skin_tone_pixel_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_tone_pixel_classifier
// Converts each RGB pixel to integer hue, lightness and saturation and
// flags it when all three fall inside the programmed center +/- margin.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one pixel (red in bits
//   7:0, green 15:8, blue 23:16) and a last-pixel flag. Output channel
//   out_valid/out_stall/result returns one mask word per pixel, all ones on
//   a match and zero otherwise, with the last flag copied through.
//   The item passes ten register stages: one for max/min, one for hue,
//   lightness and the divider operands, seven restoring divider stages
//   (one saturation quotient bit each) and the range-test output register.
//   Throughput is one pixel per clock while the output is not stalled.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles close up while the receiver stalls; a stalled output holds and
//   in_stall rises only once every stage holds a pixel.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high and unknown indexes are ignored. Write them
//   only while no pixel is in flight.
//   Reset (rst, synchronous) empties the pipeline and clears all registers.
// ----------------------------------------------------------------------------
module skin_tone_pixel_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  stcl_pkg::stcl_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output stcl_pkg::stcl_out_t                  result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [stcl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NSTG = stcl_pkg::DIV_STEPS + 3;
  localparam int OUT  = NSTG - 1;

  // Configuration registers
  logic signed [9:0] hue_center;
  logic [8:0]        hue_margin;
  logic [7:0]        lightness_center;
  logic [7:0]        lightness_margin;
  logic [6:0]        saturation_center;
  logic [6:0]        saturation_margin;

  logic [NSTG-1:0] stg_valid;
  logic [NSTG-1:0] stg_ready;

  logic                           s1_valid;
  logic                           s2_valid;
  logic [stcl_pkg::DIV_STEPS-1:0] div_valid;

  // Stage 1 registers
  logic [7:0] s1_r, s1_g, s1_b, s1_mx, s1_mn;
  logic       s1_rmax, s1_gmax, s1_last;

  // Stage 2 and divider items
  stcl_pkg::stcl_pipe_t s2_next;
  stcl_pkg::stcl_pipe_t s2_item;
  stcl_pkg::stcl_pipe_t div_item [0:stcl_pkg::DIV_STEPS];

  logic [7:0] px_r, px_g, px_b, px_mx, px_mn;
  logic       px_rmax, px_gmax;
  logic [7:0] delta;
  logic [8:0] sum;

  logic [6:0]         sat;
  logic               hit;
  logic signed [11:0] hue_x, hue_lo, hue_hi;
  logic signed [9:0]  light_x, light_lo, light_hi;
  logic signed [8:0]  sat_x, sat_lo, sat_hi;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_center        <= '0;
      hue_margin        <= '0;
      lightness_center  <= '0;
      lightness_margin  <= '0;
      saturation_center <= '0;
      saturation_margin <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stcl_pkg::REG_HUE_CENTER:        hue_center        <= $signed(cfg_data[9:0]);
        stcl_pkg::REG_HUE_MARGIN:        hue_margin        <= cfg_data[8:0];
        stcl_pkg::REG_LIGHTNESS_CENTER:  lightness_center  <= cfg_data[7:0];
        stcl_pkg::REG_LIGHTNESS_MARGIN:  lightness_margin  <= cfg_data[7:0];
        stcl_pkg::REG_SATURATION_CENTER: saturation_center <= cfg_data[6:0];
        stcl_pkg::REG_SATURATION_MARGIN: saturation_margin <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Gather the stage valid bits, first stage in bit 0
  assign stg_valid = {out_valid, div_valid, s2_valid, s1_valid};

  // Stage advance: a stage loads when empty or when its successor loads
  always_comb begin
    stg_ready[OUT] = !stg_valid[OUT] || !out_stall;
    for (int k = OUT - 1; k >= 0; k--) begin
      stg_ready[k] = !stg_valid[k] || stg_ready[k + 1];
    end
  end

  assign in_stall = !stg_ready[0];

  // Stage 1: max, min and which channel holds the max
  always_comb begin
    px_r    = in_data.pixel_word[7:0];
    px_g    = in_data.pixel_word[15:8];
    px_b    = in_data.pixel_word[23:16];
    px_rmax = (px_r >= px_g) && (px_r >= px_b);
    px_gmax = !px_rmax && (px_g >= px_b);
    px_mx   = px_rmax ? px_r : (px_gmax ? px_g : px_b);
    px_mn   = px_r;
    if (px_g < px_mn) begin
      px_mn = px_g;
    end
    if (px_b < px_mn) begin
      px_mn = px_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stg_ready[0]) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[0]) begin
      s1_r    <= px_r;
      s1_g    <= px_g;
      s1_b    <= px_b;
      s1_mx   <= px_mx;
      s1_mn   <= px_mn;
      s1_rmax <= px_rmax;
      s1_gmax <= px_gmax;
      s1_last <= in_data.last_pixel;
    end
  end

  // Stage 2: hue sector, lightness and divider operands
  always_comb begin
    delta           = s1_mx - s1_mn;
    sum             = {1'b0, s1_mx} + {1'b0, s1_mn};
    s2_next.light   = sum[8:1];
    s2_next.zero    = (sum[8:1] == 8'd0);
    s2_next.last    = s1_last;
    s2_next.rem     = {1'b0, delta, 6'd0} + {2'b00, delta, 5'd0} + {5'd0, delta, 2'd0};
    s2_next.dsor    = {sum, 6'd0};
    s2_next.quot    = '0;
    // Quotient of the hue formula is -1, 0 or 1: find it by equality tests
    if (delta == 8'd0) begin
      s2_next.hue = 10'sd0;
    end else if (s1_rmax) begin
      if (s1_g == s1_mx && s1_b == s1_mn) begin
        s2_next.hue = 10'sd60;
      end else if (s1_b == s1_mx && s1_g == s1_mn) begin
        s2_next.hue = -10'sd60;
      end else begin
        s2_next.hue = 10'sd0;
      end
    end else if (s1_gmax) begin
      if (s1_b == s1_mx && s1_r == s1_mn) begin
        s2_next.hue = 10'sd180;
      end else if (s1_r == s1_mx && s1_b == s1_mn) begin
        s2_next.hue = 10'sd60;
      end else begin
        s2_next.hue = 10'sd120;
      end
    end else begin
      if (s1_r == s1_mx && s1_g == s1_mn) begin
        s2_next.hue = 10'sd300;
      end else if (s1_g == s1_mx && s1_r == s1_mn) begin
        s2_next.hue = 10'sd180;
      end else begin
        s2_next.hue = 10'sd240;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (stg_ready[1]) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[1]) begin
      s2_item <= s2_next;
    end
  end

  assign div_item[0] = s2_item;

  // Saturation divider: one quotient bit per stage
  for (genvar i = 0; i < stcl_pkg::DIV_STEPS; i++) begin : g_div
    stcl_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (stg_ready[i + 2]),
      .in_valid  (stg_valid[i + 1]),
      .in_item   (div_item[i]),
      .out_valid (div_valid[i]),
      .out_item  (div_item[i + 1])
    );
  end

  // Final stage: inclusive range tests at full precision
  always_comb begin
    sat      = div_item[stcl_pkg::DIV_STEPS].zero ? 7'd0 :
               div_item[stcl_pkg::DIV_STEPS].quot;
    hue_x    = 12'(div_item[stcl_pkg::DIV_STEPS].hue);
    hue_hi   = 12'(hue_center) + $signed({3'b000, hue_margin});
    hue_lo   = 12'(hue_center) - $signed({3'b000, hue_margin});
    light_x  = $signed({2'b00, div_item[stcl_pkg::DIV_STEPS].light});
    light_hi = $signed({2'b00, lightness_center}) + $signed({2'b00, lightness_margin});
    light_lo = $signed({2'b00, lightness_center}) - $signed({2'b00, lightness_margin});
    sat_x    = $signed({2'b00, sat});
    sat_hi   = $signed({2'b00, saturation_center}) + $signed({2'b00, saturation_margin});
    sat_lo   = $signed({2'b00, saturation_center}) - $signed({2'b00, saturation_margin});
    hit      = (hue_x <= hue_hi) && (hue_x >= hue_lo)
            && (light_x <= light_hi) && (light_x >= light_lo)
            && (sat_x <= sat_hi) && (sat_x >= sat_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_ready[OUT]) begin
      out_valid <= stg_valid[OUT - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[OUT]) begin
      result.mask_word <= hit ? stcl_pkg::MASK_HIT : stcl_pkg::MASK_MISS;
      result.last_out  <= div_item[stcl_pkg::DIV_STEPS].last;
    end
  end

  // Checks
  a_mask_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.mask_word == stcl_pkg::MASK_HIT ||
                   result.mask_word == stcl_pkg::MASK_MISS))
    else $error("mask word is neither all ones nor zero");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !stg_valid[0] |-> !in_stall)
    else $error("input stalled while the first stage is empty");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    (stg_valid[OUT - 1] && !div_item[stcl_pkg::DIV_STEPS].zero) |->
      (div_item[stcl_pkg::DIV_STEPS].quot <= stcl_pkg::SAT_MAX))
    else $error("saturation quotient above 100");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the skin tone pixel classifier. Pixels stream in
// through a queue-fed driver with random gaps. A monitor with random stalls,
// and two long hold-offs, checks every mask word and last flag against an
// in-bench hue/lightness/saturation model. The phases step through reset,
// wide-open, edge, raw and random register settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int PIPE_DEPTH     = 10;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  // Indexes with no register behind them
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  // Corner pixels, written as {blue, green, red}
  localparam logic [23:0] CORNER_PIXELS [20] = '{
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
    24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h000001, 24'h000101,
    24'h000002, 24'h7F7F80, 24'h140A00, 24'h000A14, 24'h0A1400,
    24'h010000, 24'h804020, 24'h5A7BE0, 24'hFF00FE, 24'h00FEFF
  };

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  stcl_pkg::stcl_in_t               in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  stcl_pkg::stcl_out_t              result;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [stcl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [stcl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // Register copies used by the classifier model
  int hue_ctr, hue_mrg, light_ctr, light_mrg, sat_ctr, sat_mrg;

  stcl_pkg::stcl_in_t  pixel_queue [$];
  stcl_pkg::stcl_out_t mask_queue [$];
  stcl_pkg::stcl_out_t want;

  int  send_gap, recv_gap, hold_left;
  int  hold_requests, hold_served;
  bit  calm;
  int  errors, pixels_in, results_out, hits, stall_cycles, cfg_writes;
  int  idle_cycles;

  skin_tone_pixel_classifier uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Inclusive band test at full precision
  function automatic bit in_window(int v, int ctr, int mrg);
    return v <= ctr + mrg && v >= ctr - mrg;
  endfunction

  // Convert the pixel to hue, lightness and saturation and test the bands
  function automatic stcl_pkg::stcl_out_t classify(stcl_pkg::stcl_in_t px);
    int red, grn, blu, top, bot, span, light, hue, sat;
    stcl_pkg::stcl_out_t res;
    red = int'(px.pixel_word[7:0]);
    grn = int'(px.pixel_word[15:8]);
    blu = int'(px.pixel_word[23:16]);
    top = red;
    if (grn > top) top = grn;
    if (blu > top) top = blu;
    bot = red;
    if (grn < bot) bot = grn;
    if (blu < bot) bot = blu;
    span  = top - bot;
    light = (top + bot) / 2;
    if (span == 0) hue = 0;
    else if (top == red) hue = (((grn - blu) / span) % 6) * 60;
    else if (top == grn) hue = (((blu - red) / span) + 2) * 60;
    else hue = (((red - grn) / span) + 4) * 60;
    sat = (light != 0) ? (100 * span) / (top + bot) : 0;
    res.mask_word = (in_window(sat, sat_ctr, sat_mrg) && in_window(hue, hue_ctr, hue_mrg)
                     && in_window(light, light_ctr, light_mrg)) ? stcl_pkg::MASK_HIT
                                                                : stcl_pkg::MASK_MISS;
    res.last_out  = px.last_pixel;
    return res;
  endfunction

  // Mirror register writes as the block takes them
  always @(posedge clk) begin
    if (rst) begin
      hue_ctr   <= 0;
      hue_mrg   <= 0;
      light_ctr <= 0;
      light_mrg <= 0;
      sat_ctr   <= 0;
      sat_mrg   <= 0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_writes++;
      case (cfg_index)
        stcl_pkg::REG_HUE_CENTER:        hue_ctr   <= int'(signed'(cfg_data[9:0]));
        stcl_pkg::REG_HUE_MARGIN:        hue_mrg   <= int'(cfg_data[8:0]);
        stcl_pkg::REG_LIGHTNESS_CENTER:  light_ctr <= int'(cfg_data[7:0]);
        stcl_pkg::REG_LIGHTNESS_MARGIN:  light_mrg <= int'(cfg_data[7:0]);
        stcl_pkg::REG_SATURATION_CENTER: sat_ctr   <= int'(cfg_data[6:0]);
        stcl_pkg::REG_SATURATION_MARGIN: sat_mrg   <= int'(cfg_data[6:0]);
        default: ;
      endcase
    end
  end

  // Driver: predict on each input transfer, then offer the next pixel or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        mask_queue.push_back(classify(in_data));
        pixels_in++;
      end
      if (in_valid && in_stall) stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_out++;
        if (mask_queue.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual mask %h last %b",
                   $time, result.mask_word, result.last_out);
          errors++;
        end else begin
          want = mask_queue.pop_front();
          if (want.mask_word == stcl_pkg::MASK_HIT) hits++;
          if (result.mask_word !== want.mask_word) begin
            $display("%0t: mask_word mismatch: expected %h, actual %h",
                     $time, want.mask_word, result.mask_word);
            errors++;
          end
          if (result.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch: expected %b, actual %b",
                     $time, want.last_out, result.last_out);
            errors++;
          end
        end
      end
      if (hold_served < hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, mask_queue.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold a register write until the block takes it
  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic program_all(input int hc, input int hm, input int lc, input int lm,
                             input int sc, input int sm, input bit stray);
    if (stray) write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, 10'($urandom));
    write_reg(stcl_pkg::REG_HUE_CENTER,        10'(hc));
    write_reg(stcl_pkg::REG_HUE_MARGIN,        10'(hm));
    write_reg(stcl_pkg::REG_LIGHTNESS_CENTER,  10'(lc));
    write_reg(stcl_pkg::REG_LIGHTNESS_MARGIN,  10'(lm));
    write_reg(stcl_pkg::REG_SATURATION_CENTER, 10'(sc));
    write_reg(stcl_pkg::REG_SATURATION_MARGIN, 10'(sm));
    cfg_valid <= 1'b0;
  endtask

  // Settings near the reachable hues, now and then raw 10-bit values
  task automatic program_random();
    int hc, hm;
    hc = 60 * int'($urandom_range(0, 5)) - 60 + int'($urandom_range(0, 20)) - 10;
    hm = $urandom_range(0, 360);
    if ($urandom_range(0, 3) == 0) hc = $urandom;
    if ($urandom_range(0, 3) == 0) hm = $urandom;
    program_all(hc, hm, $urandom_range(0, 255), $urandom_range(0, 128),
                $urandom_range(0, 100), $urandom_range(0, 60), $urandom_range(0, 2) == 0);
  endtask

  // Mix of full random, near-gray, saturated and tied pixels
  function automatic stcl_pkg::stcl_in_t random_pixel();
    stcl_pkg::stcl_in_t px;
    logic [7:0] ch [3];
    int lvl, v, k;
    lvl = $urandom_range(0, 255);
    k   = $urandom_range(0, 2);
    case ($urandom_range(0, 3))
      0: begin
        px.pixel_word = 24'($urandom);
      end
      1: begin
        for (int i = 0; i < 3; i++) begin
          v = lvl + int'($urandom_range(0, 16)) - 8;
          ch[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
        px.pixel_word = {ch[2], ch[1], ch[0]};
      end
      2: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 2))
            0: ch[i] = 8'h00;
            1: ch[i] = 8'hFF;
            default: ch[i] = 8'($urandom);
          endcase
        end
        px.pixel_word = {ch[2], ch[1], ch[0]};
      end
      default: begin
        for (int i = 0; i < 3; i++) ch[i] = 8'(lvl);
        ch[k] = 8'($urandom);
        px.pixel_word = {ch[2], ch[1], ch[0]};
      end
    endcase
    px.last_pixel = ($urandom_range(0, 7) == 0);
    return px;
  endfunction

  // Wait until every pixel is sent and checked, then let the pipe settle
  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || mask_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic stream_random(input int count);
    for (int i = 0; i < count; i++) pixel_queue.push_back(random_pixel());
  endtask

  initial begin
    stcl_pkg::stcl_in_t px;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Corner pixels under the reset settings
    foreach (CORNER_PIXELS[i]) begin
      px.pixel_word = CORNER_PIXELS[i];
      px.last_pixel = i[0];
      pixel_queue.push_back(px);
    end
    drain();

    // Wide-open bands, with a long receiver hold-off to fill the pipe
    program_all(120, 360, 128, 255, 50, 100, 1'b0);
    stream_random(150);
    hold_requests <= hold_requests + 1;
    drain();

    // Bottom edges, zero margins
    program_all(-60, 0, 0, 0, 0, 0, 1'b0);
    stream_random(100);
    drain();

    // Top edges, bands that reach past the field ranges
    program_all(359, 360, 255, 255, 100, 100, 1'b0);
    stream_random(100);
    drain();

    // Raw values beyond the stated ranges, stray writes to unused indexes
    program_all(10'h200, 10'h3FF, 255, 0, 127, 127, 1'b1);
    stream_random(100);
    drain();

    // Random settings
    for (int p = 0; p < 8; p++) begin
      program_random();
      stream_random(100);
      if (p == 4) hold_requests <= hold_requests + 1;
      drain();
    end

    // Back-to-back traffic with no idling at all
    calm <= 1'b1;
    program_random();
    stream_random(80);
    drain();

    $display("Covered %0d pixels in %0d results (%0d matches), %0d register writes.",
             pixels_in, results_out, hits, cfg_writes);
    $display("Input held off for %0d cycles by a full pipeline or receiver stalls.",
             stall_cycles);
    if (errors == 0 && mask_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
